FILE: design/tch_pkg.sv
// ----------------------------------------------------------------------------
// tch_pkg: shared constants and tables for the tilt-compensated heading
// Fixed-point formats, CORDIC arctangent table and gain constant.
// ----------------------------------------------------------------------------
package tch_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAX_STEPS        = 32;

  // Datapath widths: angle (Q29), rotation datapath, vectoring datapath.
  localparam int ZW = 32;
  localparam int RW = 34;
  localparam int VW = 54;

  localparam longint PI_Q29       = 64'd1686629713;
  localparam longint HALF_PI_Q29  = 64'd843314857;
  localparam longint HALF_PI_FLR  = PI_Q29 / 2;
  localparam longint DEG_SCALE    = 180 * 128;
  localparam int     RAD_MAX      = 12868;
  localparam int     DEG_MAX      = 11520;

  // Degrees conversion: q = mag * DEG_SCALE / pi through a reciprocal.
  localparam int     DIV_SHIFT    = 46;
  localparam longint DIV_K        = (DEG_SCALE << DIV_SHIFT) / PI_Q29;

  // Arctangent of 2^-i in radians, Q29.
  function automatic logic [ZW-1:0] atan_q29(input int i);
    logic [ZW-1:0] v;
    case (i)
      0:       v = 32'd421657428;
      1:       v = 32'd248918915;
      2:       v = 32'd131521918;
      3:       v = 32'd66762579;
      4:       v = 32'd33510843;
      5:       v = 32'd16771758;
      6:       v = 32'd8387925;
      7:       v = 32'd4194219;
      8:       v = 32'd2097141;
      9:       v = 32'd1048575;
      10:      v = 32'd524288;
      // At step 30 the angle is half an LSB, which rounds up to one.
      default: v = (i <= 29) ? (32'd1 << (29 - i)) : ((i == 30) ? 32'd1 : 32'd0);
    endcase
    return v;
  endfunction

  // Inverse CORDIC gain in Q30 for a given step count, evaluated at elaboration.
  function automatic logic [RW-1:0] gain_inv_q30(input int steps);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] num;
    p = 64'd1 << 30;
    for (int i = 0; i < MAX_STEPS; i++) begin
      if (i < steps) p = p + (p >> (2 * i));
    end
    v = p << 30;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    num = 64'd1 << 60;
    rem = 64'd0;
    quo = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 1) | ((num >> k) & 64'd1);
      if (rem >= r) begin
        rem = rem - r;
        quo = quo | (64'd1 << k);
      end
    end
    return quo[RW-1:0];
  endfunction

endpackage

FILE: design/tch_rot_cell.sv
// ----------------------------------------------------------------------------
// tch_rot_cell: one rotation-mode CORDIC step
// Turns the vector toward the residual angle by atan(2^-STEP), registered.
// ----------------------------------------------------------------------------
module tch_rot_cell #(
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [tch_pkg::RW-1:0] x_in,
  input  logic signed [tch_pkg::RW-1:0] y_in,
  input  logic signed [tch_pkg::ZW-1:0] z_in,
  output logic signed [tch_pkg::RW-1:0] x_out,
  output logic signed [tch_pkg::RW-1:0] y_out,
  output logic signed [tch_pkg::ZW-1:0] z_out
);

  localparam logic signed [tch_pkg::ZW-1:0] ATAN = signed'(tch_pkg::atan_q29(STEP));

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x_out <= x_in - (y_in >>> STEP);
        y_out <= y_in + (x_in >>> STEP);
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + (y_in >>> STEP);
        y_out <= y_in - (x_in >>> STEP);
        z_out <= z_in + ATAN;
      end
    end
  end

endmodule

FILE: design/tch_vec_cell.sv
// ----------------------------------------------------------------------------
// tch_vec_cell: one vectoring-mode CORDIC step
// Drives y toward zero by atan(2^-STEP) and accumulates the angle, registered.
// ----------------------------------------------------------------------------
module tch_vec_cell #(
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [tch_pkg::VW-1:0] x_in,
  input  logic signed [tch_pkg::VW-1:0] y_in,
  input  logic signed [tch_pkg::ZW-1:0] z_in,
  output logic signed [tch_pkg::VW-1:0] x_out,
  output logic signed [tch_pkg::VW-1:0] y_out,
  output logic signed [tch_pkg::ZW-1:0] z_out
);

  localparam logic signed [tch_pkg::ZW-1:0] ATAN = signed'(tch_pkg::atan_q29(STEP));

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in >= 0) begin
        x_out <= x_in + (y_in >>> STEP);
        y_out <= y_in - (x_in >>> STEP);
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - (y_in >>> STEP);
        y_out <= y_in + (x_in >>> STEP);
        z_out <= z_in - ATAN;
      end
    end
  end

endmodule

FILE: design/tilt_compensated_heading.sv
// ----------------------------------------------------------------------------
// tilt_compensated_heading: tilt-compensated compass heading
// Rotates the magnetometer field by pitch and roll and returns atan(yh/xh).
// ----------------------------------------------------------------------------
// Usage: an input beat carries pitch_angle, roll_angle (Q3.12 rad) and
// field_x/y/z (Q5.11 gauss) on in_valid; the block raises in_stall to hold
// it off. Each input beat yields one output beat, heading, on out_valid.
// heading is radians Q2.13 when radians_mode is 1, degrees Q8.7 when 0;
// Write radians_mode through cfg_we/cfg_wdata only while the block is idle;
// the block does not enforce it. Stages: one input stage, a row of sine and
// cosine cells, rounding, three multiply stages, sign fold, a row of
// arctangent cells and three output-scaling stages. The pipeline accepts a
// beat every cycle unless held. All stages advance together; while out_valid
// and out_stall are high the whole pipeline holds and in_stall is high, so no
// beat is lost. Synchronous reset clears all valid bits and sets degrees mode.
// ----------------------------------------------------------------------------
module tilt_compensated_heading #(
  parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF,
  parameter int SAMPLE_WIDTH = tch_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] pitch_angle,
  input  logic signed [14:0] roll_angle,
  input  logic signed [15:0] field_x,
  input  logic signed [15:0] field_y,
  input  logic signed [15:0] field_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] heading
);

  localparam int ZW = tch_pkg::ZW;
  localparam int RW = tch_pkg::RW;
  localparam int VW = tch_pkg::VW;
  localparam int NSTEPS = (CORDIC_STEPS > tch_pkg::MAX_STEPS) ? tch_pkg::MAX_STEPS :
                          ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
  localparam int LAT = 2 * NSTEPS + 9;
  localparam int DROP = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;
  localparam logic [15:0] FMASK = (16'hFFFF >> DROP) << DROP;
  localparam logic signed [RW-1:0] GAIN = signed'(tch_pkg::gain_inv_q30(NSTEPS));
  localparam logic signed [ZW:0] HALF_PI = 33'(tch_pkg::HALF_PI_Q29);
  localparam logic signed [ZW:0] PI_S    = 33'(tch_pkg::PI_Q29);
  localparam logic [45:0] PI_U      = 46'(tch_pkg::PI_Q29);
  localparam logic [45:0] HALF_FLR  = 46'(tch_pkg::HALF_PI_FLR);
  localparam logic [29:0] DIV_K     = 30'(tch_pkg::DIV_K);
  localparam logic [14:0] DSCALE    = 15'(tch_pkg::DEG_SCALE);
  localparam logic [60:0] DIV_RND   = 61'd1 << (tch_pkg::DIV_SHIFT - 1);
  localparam logic [15:0] RAD_MAX   = 16'(tch_pkg::RAD_MAX);
  localparam logic [14:0] DEG_MAX   = 15'(tch_pkg::DEG_MAX);

  logic           adv;
  logic [LAT-1:0] vld;
  logic           radians_mode;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      radians_mode <= 1'b0;
    end else begin
      if (adv) vld <= {vld[LAT-2:0], in_valid};
      if (cfg_we) radians_mode <= cfg_wdata;
    end
  end

  // Bring the angle to Q29 and fold it into -pi/2..pi/2; the MSB is the flip.
  function automatic logic [ZW:0] fold(input logic signed [14:0] a);
    logic signed [ZW:0] z;
    logic               f;
    z = signed'({{18{a[14]}}, a}) <<< 17;
    f = 1'b0;
    if (z > HALF_PI) begin
      z = z - PI_S;
      f = 1'b1;
    end else if (z < -HALF_PI) begin
      z = z + PI_S;
      f = 1'b1;
    end
    return {f, z[ZW-1:0]};
  endfunction

  function automatic logic signed [17:0] rnd16(input logic signed [RW-1:0] v,
                                               input logic f);
    logic signed [RW-1:0] t;
    t = f ? -v : v;
    t = t + RW'(8192);
    return 18'(t >>> 14);
  endfunction

  // Sine and cosine rows.
  logic signed [RW-1:0] px [0:NSTEPS];
  logic signed [RW-1:0] py [0:NSTEPS];
  logic signed [ZW-1:0] pz [0:NSTEPS];
  logic signed [RW-1:0] rx [0:NSTEPS];
  logic signed [RW-1:0] ry [0:NSTEPS];
  logic signed [ZW-1:0] rz [0:NSTEPS];
  logic signed [15:0]   fx_p [0:NSTEPS];
  logic signed [15:0]   fy_p [0:NSTEPS];
  logic signed [15:0]   fz_p [0:NSTEPS];
  logic                 pf_p [0:NSTEPS];
  logic                 rf_p [0:NSTEPS];
  logic [ZW:0]          pfold;
  logic [ZW:0]          rfold;

  assign pfold = fold(pitch_angle);
  assign rfold = fold(roll_angle);

  always_ff @(posedge clk) begin
    if (adv) begin
      px[0]   <= GAIN;
      py[0]   <= '0;
      pz[0]   <= signed'(pfold[ZW-1:0]);
      pf_p[0] <= pfold[ZW];
      rx[0]   <= GAIN;
      ry[0]   <= '0;
      rz[0]   <= signed'(rfold[ZW-1:0]);
      rf_p[0] <= rfold[ZW];
      fx_p[0] <= signed'(field_x & FMASK);
      fy_p[0] <= signed'(field_y & FMASK);
      fz_p[0] <= signed'(field_z & FMASK);
    end
  end

  for (genvar k = 0; k < NSTEPS; k++) begin : g_rot
    tch_rot_cell #(.STEP(k)) u_pitch (
      .clk(clk), .en(adv),
      .x_in(px[k]), .y_in(py[k]), .z_in(pz[k]),
      .x_out(px[k+1]), .y_out(py[k+1]), .z_out(pz[k+1])
    );
    tch_rot_cell #(.STEP(k)) u_roll (
      .clk(clk), .en(adv),
      .x_in(rx[k]), .y_in(ry[k]), .z_in(rz[k]),
      .x_out(rx[k+1]), .y_out(ry[k+1]), .z_out(rz[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        fx_p[k+1] <= fx_p[k];
        fy_p[k+1] <= fy_p[k];
        fz_p[k+1] <= fz_p[k];
        pf_p[k+1] <= pf_p[k];
        rf_p[k+1] <= rf_p[k];
      end
    end
  end

  // Rounding to Q16.
  logic signed [17:0] sp, cp, sr, cr;
  logic signed [15:0] fx_r, fy_r, fz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cp   <= rnd16(px[NSTEPS], pf_p[NSTEPS]);
      sp   <= rnd16(py[NSTEPS], pf_p[NSTEPS]);
      cr   <= rnd16(rx[NSTEPS], rf_p[NSTEPS]);
      sr   <= rnd16(ry[NSTEPS], rf_p[NSTEPS]);
      fx_r <= fx_p[NSTEPS];
      fy_r <= fy_p[NSTEPS];
      fz_r <= fz_p[NSTEPS];
    end
  end

  // Horizontal projection, first products.
  logic signed [33:0] m_a, m_b, m_c, m_d, m_e;
  logic signed [17:0] sr_m, cp_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_a  <= fx_r * cp;
      m_b  <= fz_r * sp;
      m_c  <= fx_r * sp;
      m_d  <= fy_r * cr;
      m_e  <= fz_r * sr;
      sr_m <= sr;
      cp_m <= cp;
    end
  end

  // Second products.
  logic signed [VW-1:0] xh2, t_c, t_d, t_e;
  logic signed [34:0]   ab_sum;

  assign ab_sum = 35'(m_a) + 35'(m_b);

  always_ff @(posedge clk) begin
    if (adv) begin
      xh2 <= VW'(ab_sum) <<< 16;
      t_c <= VW'(m_c) * VW'(sr_m);
      t_d <= VW'(m_d) <<< 16;
      t_e <= VW'(m_e) * VW'(cp_m);
    end
  end

  logic signed [VW-1:0] xh3, yh3;

  always_ff @(posedge clk) begin
    if (adv) begin
      xh3 <= xh2;
      yh3 <= t_c + t_d - t_e;
    end
  end

  // Arctangent row; the vector is moved to the right half-plane first.
  logic signed [VW-1:0] vx [0:NSTEPS];
  logic signed [VW-1:0] vy [0:NSTEPS];
  logic signed [ZW-1:0] vz [0:NSTEPS];
  logic                 xz_p [0:NSTEPS];
  logic                 yz_p [0:NSTEPS];
  logic                 yn_p [0:NSTEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      vx[0]   <= (xh3 < 0) ? -xh3 : xh3;
      vy[0]   <= (xh3 < 0) ? -yh3 : yh3;
      vz[0]   <= '0;
      xz_p[0] <= (xh3 == 0);
      yz_p[0] <= (yh3 == 0);
      yn_p[0] <= (yh3 < 0);
    end
  end

  for (genvar k = 0; k < NSTEPS; k++) begin : g_vec
    tch_vec_cell #(.STEP(k)) u_cell (
      .clk(clk), .en(adv),
      .x_in(vx[k]), .y_in(vy[k]), .z_in(vz[k]),
      .x_out(vx[k+1]), .y_out(vy[k+1]), .z_out(vz[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        xz_p[k+1] <= xz_p[k];
        yz_p[k+1] <= yz_p[k];
        yn_p[k+1] <= yn_p[k];
      end
    end
  end

  // Output scaling.
  logic [30:0] mag1;
  logic [60:0] prod1;
  logic        neg1, xz1, yz1, yn1;
  logic [30:0] mag_abs;

  assign mag_abs = 31'((vz[NSTEPS] < 0) ? -vz[NSTEPS] : vz[NSTEPS]);

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1  <= mag_abs;
      prod1 <= mag_abs * DIV_K;
      neg1  <= (vz[NSTEPS] < 0);
      xz1   <= xz_p[NSTEPS];
      yz1   <= yz_p[NSTEPS];
      yn1   <= yn_p[NSTEPS];
    end
  end

  logic [14:0] qe2;
  logic [45:0] qpi2, num2;
  logic [15:0] rad2;
  logic        neg2, xz2, yz2, yn2;
  logic [14:0] qe_now;
  logic [31:0] rad_sum;

  assign qe_now  = 15'((prod1 + DIV_RND) >> tch_pkg::DIV_SHIFT);
  assign rad_sum = 32'(mag1) + 32'd32768;

  always_ff @(posedge clk) begin
    if (adv) begin
      qe2  <= qe_now;
      qpi2 <= 46'(qe_now * PI_U);
      num2 <= 46'(mag1) * 46'(DSCALE) + HALF_FLR;
      rad2 <= rad_sum[31:16];
      neg2 <= neg1;
      xz2  <= xz1;
      yz2  <= yz1;
      yn2  <= yn1;
    end
  end

  logic [45:0] rem3;
  logic [14:0] q3;
  logic [14:0] deg3;
  logic [14:0] rad3;
  logic [14:0] mag3;
  logic [14:0] res3;

  always_comb begin
    rem3 = num2 - qpi2;
    q3   = qe2 + 15'(rem3 >= PI_U);
    deg3 = (q3 > DEG_MAX) ? DEG_MAX : q3;
    rad3 = (rad2 > RAD_MAX) ? 15'(RAD_MAX) : 15'(rad2);
    mag3 = radians_mode ? rad3 : deg3;
    if (xz2) begin
      // Vertical vector: a quarter turn by the sign of yh, zero if both vanish.
      if (yz2)               res3 = '0;
      else if (radians_mode) res3 = 15'(RAD_MAX);
      else                   res3 = DEG_MAX;
      if (yn2) res3 = -res3;
    end else begin
      res3 = neg2 ? -mag3 : mag3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) heading <= signed'(res3);
  end

endmodule

FILE: tb/tb_tilt_compensated_heading.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilt_compensated_heading: self-checking bench for the compass heading
// A queue-fed driver offers pitch, roll and field beats with random gaps, a
// monitor takes headings under random stall, and a bit-exact heading
// predictor checks each one in both degrees and radians modes.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_heading;

  localparam int     STEPS      = 16;
  localparam int     LATENCY    = 2 * STEPS + 9;
  localparam longint PI_Q29     = 1686629713;
  localparam longint HALF_PI_Q29 = 843314857;
  localparam longint QTR_PI_Q29 = 421657428;
  localparam longint DEG_SCALE  = 180 * 128;
  localparam longint RAD_MAX    = 12868;
  localparam longint DEG_MAX    = 11520;
  localparam int     IDLE_LIMIT = 3000;
  localparam bit     MODE_DEG   = 1'b0;
  localparam bit     MODE_RAD   = 1'b1;

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
  } sample_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [14:0] pitch_angle = '0;
  logic signed [14:0] roll_angle = '0;
  logic signed [15:0] field_x = '0;
  logic signed [15:0] field_y = '0;
  logic signed [15:0] field_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] heading;

  sample_t       pending_q[$];
  logic [14:0]   heading_q[$];
  longint        atan_q29[STEPS];
  longint        gain_inv;
  bit            mode_rad = MODE_DEG;
  bit            steady = 1'b0;
  int            errors = 0;
  int            n_in = 0;
  int            n_out = 0;
  int            n_rad = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            hold_left = 0;
  int            idle_cycles = 0;

  tilt_compensated_heading u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .pitch_angle(pitch_angle), .roll_angle(roll_angle),
    .field_x(field_x), .field_y(field_y), .field_z(field_z),
    .out_valid(out_valid), .out_stall(out_stall), .heading(heading)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void build_angle_tables();
    longint          sum;
    longint          term;
    longint unsigned p;
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    int              e;
    atan_q29[0] = QTR_PI_Q29;
    for (int i = 1; i < STEPS; i++) begin
      sum = 0;
      for (int k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e > 60) break;
        term = (longint'(1) << (60 - e)) / (2 * k + 1);
        sum += (k & 1) ? -term : term;
      end
      atan_q29[i] = (sum + (longint'(1) << 30)) >>> 31;
    end
    p = 64'd1 << 30;
    for (int i = 0; i < STEPS; i++) p += p >> (2 * i);
    v = p << 30;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    gain_inv = longint'((64'd1 << 60) / r);
  endfunction

  // Rotation CORDIC: Q3.12 angle in, sine and cosine out in Q16.
  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint z;
    longint x;
    longint y;
    longint t;
    bit     flip;
    z = ang * (longint'(1) << 17);
    x = gain_inv;
    y = 0;
    flip = 1'b0;
    if (z > HALF_PI_Q29) begin
      z -= PI_Q29;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q29) begin
      z += PI_Q29;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_q29[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_q29[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + (1 << 13)) >>> 14;
    s = (y + (1 << 13)) >>> 14;
  endfunction

  function automatic logic [14:0] predict_heading(input sample_t smp, input bit rad);
    longint sp, cp, sr, cr, fx, fy, fz, xh, yh, x, y, t, z, mag, res;
    bit     neg;
    sin_cos(longint'(smp.pitch), sp, cp);
    sin_cos(longint'(smp.roll), sr, cr);
    fx = smp.fx;
    fy = smp.fy;
    fz = smp.fz;
    xh = (fx * cp + fz * sp) * 65536;
    yh = fx * sp * sr + fy * cr * 65536 - fz * sr * cp;
    if (xh == 0) begin
      res = (yh == 0) ? 0 : (rad ? RAD_MAX : DEG_MAX);
      if (yh < 0) res = -res;
    end else begin
      x = xh;
      y = yh;
      z = 0;
      // Negating both keeps the quotient, so the result stays in the half-plane.
      if (x < 0) begin
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        if (y >= 0) begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_q29[i];
        end else begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_q29[i];
        end
      end
      neg = z < 0;
      mag = neg ? -z : z;
      if (rad) begin
        res = (mag + 32768) >>> 16;
        if (res > RAD_MAX) res = RAD_MAX;
      end else begin
        res = (mag * DEG_SCALE + PI_Q29 / 2) / PI_Q29;
        if (res > DEG_MAX) res = DEG_MAX;
      end
      if (neg) res = -res;
    end
    return res[14:0];
  endfunction

  function automatic sample_t random_sample();
    sample_t smp;
    int      kind;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      smp.pitch = 15'($urandom);
      smp.roll = 15'($urandom);
    end else begin
      smp.pitch = 15'($urandom_range(0, 25736) - 12868);
      smp.roll = 15'($urandom_range(0, 25736) - 12868);
    end
    smp.fx = 16'($urandom);
    smp.fy = 16'($urandom);
    smp.fz = 16'($urandom);
    if (kind == 1) begin
      smp.fx = 16'($urandom_range(0, 64) - 32);
      smp.fy = 16'($urandom_range(0, 64) - 32);
      smp.fz = 16'($urandom_range(0, 64) - 32);
    end else if (kind == 2) begin
      // Zero pitch with no x or z field leaves xh at zero.
      smp.pitch = '0;
      smp.fx = '0;
      smp.fz = '0;
    end
    return smp;
  endfunction

  function automatic sample_t mk(input int p, input int r, input int x, input int y,
                                 input int z);
    sample_t smp;
    smp.pitch = 15'(p);
    smp.roll = 15'(r);
    smp.fx = 16'(x);
    smp.fy = 16'(y);
    smp.fz = 16'(z);
    return smp;
  endfunction

  task automatic queue_directed();
    pending_q.push_back(mk(0, 0, 0, 0, 0));
    pending_q.push_back(mk(0, 0, 0, 1000, 0));
    pending_q.push_back(mk(0, 0, 0, -1000, 0));
    pending_q.push_back(mk(0, 0, 2048, 2048, 0));
    pending_q.push_back(mk(0, 0, -2048, 2048, 0));
    pending_q.push_back(mk(0, 0, -2048, -2048, 500));
    pending_q.push_back(mk(12868, 12868, 32767, 32767, 32767));
    pending_q.push_back(mk(-12868, -12868, -32768, -32768, -32768));
    pending_q.push_back(mk(16383, -16384, 32767, -32768, 32767));
    pending_q.push_back(mk(-16384, 16383, -32768, 32767, -32768));
    pending_q.push_back(mk(6434, -6434, 1000, -3000, 2000));
    pending_q.push_back(mk(6500, 7000, 3000, 100, -4000));
    pending_q.push_back(mk(-9000, 3000, -1, 1, -1));
    pending_q.push_back(mk(0, 0, 1, 32767, 0));
    pending_q.push_back(mk(0, 0, 32767, 0, 0));
    pending_q.push_back(mk(1, -1, 20000, -20000, 15000));
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || heading_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_mode(input bit val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_rad = val;
  endtask

  // Driver: one beat per draw, each followed by a random gap unless steady.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        heading_q.push_back(predict_heading('{pitch_angle, roll_angle, field_x, field_y,
                                              field_z}, mode_rad));
        n_in++;
        if (mode_rad) n_rad++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          sample_t smp;
          smp = pending_q.pop_front();
          pitch_angle <= smp.pitch;
          roll_angle <= smp.roll;
          field_x <= smp.fx;
          field_y <= smp.fy;
          field_z <= smp.fz;
          in_valid <= 1'b1;
          gap_left = steady ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each heading beat and draws the next stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (heading_q.size() == 0) begin
          report_mismatch($sformatf("unexpected heading %0d", heading));
        end else begin
          logic [14:0] want;
          want = heading_q.pop_front();
          if (heading !== want)
            report_mismatch($sformatf("heading %0d, expected %0d", heading,
                                      $signed(want)));
        end
        n_out++;
        stall_left = steady ? 0 : $urandom_range(0, 6);
        if (n_out == 300) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[tilt_compensated_heading] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    build_angle_tables();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    queue_directed();
    wait_drained();
    write_mode(MODE_RAD);
    queue_directed();
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0] ? MODE_DEG : MODE_RAD);
      steady = (ph == 2);
      for (int i = 0; i < 470; i++) pending_q.push_back(random_sample());
      wait_drained();
    end
    $display("Checked %0d headings from %0d beats, %0d of them in radians mode.",
             n_out, n_in, n_rad);
    $display("Covered both modes, zero and negative xh, folded angles and a long stall.");
    if (errors == 0) begin
      $display("[tilt_compensated_heading] OK");
    end else begin
      $display("[tilt_compensated_heading] ERROR");
    end
    $finish;
  end

endmodule
